### hw/rtl/tsr_pkg.sv
package tsr_pkg;

    localparam int FRAC_BITS = 16;
    localparam longint Q_ONE = longint'(1) << FRAC_BITS;
    // 1 mm and 0.1 m/s thresholds, rounded up
    localparam logic [32:0] POS_EPS = 33'((Q_ONE + 999) / 1000);
    localparam logic [31:0] VEL_EPS = 32'((Q_ONE + 9) / 10);

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [9:0] RATE_RESET = 10'd30;

    // shared divider geometry
    localparam int DIV_DW = 64;   // dividend / quotient bits
    localparam int DIV_VW = 34;   // divisor bits
    localparam int DIV_CW = 7;    // step counter bits
    localparam logic [DIV_CW-1:0] DIV_STEPS_LONG = DIV_CW'(64);
    localparam logic [DIV_CW-1:0] DIV_STEPS_HALF = DIV_CW'(32);

    typedef enum logic [1:0] {
        CMD_STEP  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_JUMP  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIST,
        S_MUL,
        S_DEC,
        S_QDIV,
        S_ASTART,
        S_ADIV,
        S_VDIV,
        S_NEXT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic half;   // 32-bit dividend in the upper half, 32 steps
    } t_div_req;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
        if (x > 34'(S32_MAX)) begin
            return S32_MAX;
        end else if (x < 34'(S32_MIN)) begin
            return S32_MIN;
        end
        return x[31:0];
    endfunction

endpackage

### hw/rtl/tsr_in_if.sv
interface tsr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [30:0]        accel_limit;
    logic [30:0]        vel_limit;

    modport source (output valid, cmd, target_x, target_y, target_z, accel_limit,
                    vel_limit, input ready);
    modport sink (input valid, cmd, target_x, target_y, target_z, accel_limit,
                  vel_limit, output ready);
endinterface

### hw/rtl/tsr_out_if.sv
interface tsr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
    logic [2:0]         done_mask;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    acc_x, acc_y, acc_z, done_mask, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  acc_x, acc_y, acc_z, done_mask, output ready);
endinterface

### hw/rtl/tsr_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module tsr_div
    import tsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    input  logic [DIV_DW-1:0] i_dividend,
    input  logic [DIV_VW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_DW-1:0] o_quot
);
    logic [DIV_VW:0]   r_rem, n_rem;
    logic [DIV_DW-1:0] r_quo, n_quo;
    logic [DIV_VW-1:0] r_dvs;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [DIV_VW:0]   rem_sh;
    logic              fit;

    always_comb begin
        rem_sh = {r_rem[DIV_VW-1:0], r_quo[DIV_DW-1]};
        fit    = rem_sh >= {1'b0, r_dvs};
        n_rem  = fit ? rem_sh - {1'b0, r_dvs} : rem_sh;
        n_quo  = {r_quo[DIV_DW-2:0], fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.half ? DIV_STEPS_HALF : DIV_STEPS_LONG;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CW'(1);
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

### hw/rtl/trapezoid_setpoint_ramp_3axis.sv
// channel | dir | payload                                   | accepted when
// i_in    | in  | cmd, target_x/y/z, accel_limit, vel_limit | valid && ready
// o_out   | out | pos/vel/acc x/y/z, done_mask              | valid && ready
// cfg     | in  | i_cfg_wdata = tick_rate                   | i_cfg_we
//
// Sequence: a step word runs the three axes in turn through one shared
// bit-serial divider: a moving axis divides its acceleration, then its new
// velocity, by tick_rate, and a braking axis first divides v^2 by 2d; an axis
// inside the 1 mm band skips the divider. Clear/jump words go to the output.
// Reset is synchronous and clears the FSM and profile state; tick_rate -> 30.
// Input ready is low from accept until the result word is taken.
module trapezoid_setpoint_ramp_3axis
    import tsr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsr_in_if.sink     i_in,
    tsr_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [9:0] i_cfg_wdata
);
    t_state r_state, n_state;

    logic [9:0]         r_rate;
    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_acc [3];
    logic [2:0]         r_done;

    // latched input word
    logic signed [31:0] r_tgt [3];
    logic [30:0]        r_a, r_vlim;

    // per-axis working regs
    logic [1:0]         r_k;
    logic [32:0]        r_ad;
    logic [31:0]        r_av;
    logic               r_dpos;
    logic [63:0]        r_v2, r_aad;
    logic signed [31:0] r_acc_w;

    t_div_req           div_req;
    logic [DIV_DW-1:0]  div_dividend, div_quot;
    logic [DIV_VW-1:0]  div_divisor;
    logic               div_done;

    logic signed [32:0] d_w;
    logic               brake;
    logic [31:0]        acc_mag;
    logic signed [33:0] q_s, v_sum, p_sum;
    logic signed [31:0] v_new, p_new, q_acc;
    logic [9:0]         rate_eff;

    assign rate_eff = (r_rate == '0) ? 10'd1 : r_rate;
    assign d_w      = 33'(r_tgt[r_k]) - 33'(r_pos[r_k]);
    assign brake    = {1'b0, r_v2} >= {r_aad, 1'b0};
    assign acc_mag  = r_acc_w[31] ? 32'(-r_acc_w) : 32'(r_acc_w);
    assign q_s      = (r_acc_w[31] && r_state == S_ADIV) ||
                      (r_vel[r_k][31] && r_state == S_VDIV)
                      ? -34'(div_quot[31:0]) : 34'(div_quot[31:0]);
    assign v_sum    = 34'(r_vel[r_k]) + q_s;
    assign v_new    = sat32(v_sum);
    assign p_sum    = 34'(r_pos[r_k]) + q_s;
    assign p_new    = sat32(p_sum);

    // brake acceleration: quotient with the sign opposite to d, saturated
    always_comb begin
        if (r_dpos) begin
            q_acc = (div_quot > 64'h8000_0000) ? S32_MIN : 32'(64'd0 - div_quot);
        end else begin
            q_acc = (div_quot > 64'h7FFF_FFFF) ? S32_MAX : div_quot[31:0];
        end
    end

    always_comb begin
        n_state      = r_state;
        div_req      = '0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (t_cmd'(i_in.cmd) == CMD_STEP) ? S_DIST : S_OUT;
                end
            end
            S_DIST: n_state = S_MUL;
            S_MUL:  n_state = S_DEC;
            S_DEC: begin
                if (r_ad < POS_EPS) begin
                    n_state = S_NEXT;
                end else if (brake) begin
                    div_req.start = 1'b1;
                    div_dividend  = r_v2;
                    div_divisor   = {r_ad, 1'b0};
                    n_state       = S_QDIV;
                end else begin
                    n_state = S_ASTART;
                end
            end
            S_QDIV: if (div_done) n_state = S_ASTART;
            S_ASTART: begin
                div_req.start = 1'b1;
                div_req.half  = 1'b1;
                div_dividend  = {acc_mag, 32'd0};
                div_divisor   = DIV_VW'(rate_eff);
                n_state       = S_ADIV;
            end
            S_ADIV: begin
                if (div_done) begin
                    div_req.start = 1'b1;
                    div_req.half  = 1'b1;
                    div_dividend  = {v_new[31] ? 32'(-v_new) : 32'(v_new), 32'd0};
                    div_divisor   = DIV_VW'(rate_eff);
                    n_state       = S_VDIV;
                end
            end
            S_VDIV: if (div_done) n_state = S_NEXT;
            S_NEXT: n_state = (r_k == 2'd2) ? S_OUT : S_DIST;
            S_OUT:  if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg_we) begin
            r_rate <= i_cfg_wdata;
        end
    end

    // profile state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_acc[i] <= '0;
            end
            r_done <= '0;
            r_k    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (i_in.valid) begin
                        case (t_cmd'(i_in.cmd))
                            CMD_CLEAR: r_done <= '0;
                            CMD_JUMP: begin
                                r_pos[0] <= i_in.target_x;
                                r_pos[1] <= i_in.target_y;
                                r_pos[2] <= i_in.target_z;
                                r_done   <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DEC: begin
                    if (r_ad < POS_EPS) begin
                        if (r_av < VEL_EPS) begin
                            // settle: snap to target
                            r_pos[r_k]  <= r_tgt[r_k];
                            r_vel[r_k]  <= '0;
                            r_acc[r_k]  <= '0;
                            r_done[r_k] <= 1'b1;
                        end
                    end else begin
                        r_done[r_k] <= 1'b0;
                    end
                end
                S_ADIV: begin
                    if (div_done) begin
                        r_vel[r_k] <= v_new;
                        r_acc[r_k] <= r_acc_w;
                    end
                end
                S_VDIV: if (div_done) r_pos[r_k] <= p_new;
                S_NEXT: r_k <= r_k + 2'd1;
                default: ;
            endcase
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_tgt[0] <= i_in.target_x;
                r_tgt[1] <= i_in.target_y;
                r_tgt[2] <= i_in.target_z;
                r_a      <= i_in.accel_limit;
                r_vlim   <= i_in.vel_limit;
            end
            S_DIST: begin
                r_ad   <= d_w[32] ? 33'(-d_w) : 33'(d_w);
                r_dpos <= !d_w[32] && (d_w != '0);
                r_av   <= r_vel[r_k][31] ? 32'(-r_vel[r_k]) : 32'(r_vel[r_k]);
            end
            S_MUL: begin
                r_v2  <= r_av * r_av;
                r_aad <= 64'(r_a) * 64'(r_ad);
            end
            S_DEC: begin
                if (r_av > 32'(r_vlim)) begin
                    r_acc_w <= '0;           // coast
                end else begin
                    r_acc_w <= r_dpos ? 32'(r_a) : -32'(r_a);
                end
            end
            S_QDIV: if (div_done) r_acc_w <= q_acc;
            default: ;
        endcase
    end

    tsr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.pos_x     = r_pos[0];
    assign o_out.pos_y     = r_pos[1];
    assign o_out.pos_z     = r_pos[2];
    assign o_out.vel_x     = r_vel[0];
    assign o_out.vel_y     = r_vel[1];
    assign o_out.vel_z     = r_vel[2];
    assign o_out.acc_x     = r_acc[0];
    assign o_out.acc_y     = r_acc[1];
    assign o_out.acc_z     = r_acc[2];
    assign o_out.done_mask = r_done;
endmodule
